// ===== src/psebp_pkg.sv =====
`default_nettype none

package psebp_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_INDEX    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_IV_SIZE = 2'd1;

  // Result kinds.
  localparam logic [1:0] KIND_IV_BYTE     = 2'd0;
  localparam logic [1:0] KIND_ENTRY_COUNT = 2'd1;
  localparam logic [1:0] KIND_ENTRY       = 2'd2;
  localparam logic [1:0] KIND_ERROR       = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_PARAM = 2'd1;
  localparam logic [1:0] STATUS_BAD_DRM   = 2'd2;

  // Box layout.
  localparam logic [4:0] HEADER_BYTES = 5'd24;
  localparam logic [4:0] UUID_START   = 5'd8;
  localparam logic [4:0] ENTRY_BYTES  = 5'd6;
  localparam logic [7:0] IV_SIZE_ZERO_MEANS = 8'd8;

  // Queue depth between stages; a power of two, at least two.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // One box byte as it enters the block.
  typedef struct packed {
    logic [7:0] box_byte;
    logic       last_byte;
  } in_item_t;

  // A box byte with its header classification.
  typedef struct packed {
    logic [7:0] box_byte;
    logic       last_byte;
    logic       uuid_bad;
    logic       header_done;
  } tag_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  iv_byte;
    logic [15:0] entry_count;
    logic [15:0] clear_bytes;
    logic [31:0] encrypted_bytes;
    logic [1:0]  status;
    logic        final_res;
  } result_t;

  // Expected UUID of the sample encryption box, byte by byte.
  function automatic logic [7:0] uuid_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'hA2;
      4'd1:    val = 8'h39;
      4'd2:    val = 8'h4F;
      4'd3:    val = 8'h52;
      4'd4:    val = 8'h5A;
      4'd5:    val = 8'h9B;
      4'd6:    val = 8'h4F;
      4'd7:    val = 8'h14;
      4'd8:    val = 8'hA2;
      4'd9:    val = 8'h44;
      4'd10:   val = 8'h6C;
      4'd11:   val = 8'h42;
      4'd12:   val = 8'h7C;
      4'd13:   val = 8'h64;
      4'd14:   val = 8'h8D;
      default: val = 8'hF4;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/psebp_ifs.sv =====
`default_nettype none

// Box byte channel.
interface psebp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] box_byte;
  logic       last_byte;

  modport source (output valid, output box_byte, output last_byte, input ready);
  modport sink (input valid, input box_byte, input last_byte, output ready);
endinterface

// Result channel.
interface psebp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  iv_byte;
  logic [15:0] entry_count;
  logic [15:0] clear_bytes;
  logic [31:0] encrypted_bytes;
  logic [1:0]  status;
  logic        final_res;

  modport source (output valid, output kind, output iv_byte, output entry_count,
                  output clear_bytes, output encrypted_bytes, output status,
                  output final_res, input ready);
  modport sink (input valid, input kind, input iv_byte, input entry_count,
                input clear_bytes, input encrypted_bytes, input status,
                input final_res, output ready);
endinterface

// Configuration write channel.
interface psebp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psebp_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/psebp_queue.sv =====
`default_nettype none

module psebp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == FULL_FILL);
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/psebp_front.sv =====
`default_nettype none

module psebp_front #(
  parameter int DEPTH = psebp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  psebp_in_if.sink              box,
  output psebp_pkg::tag_item_t  item,
  output logic                  item_valid,
  input  wire logic             item_pop
);

  import psebp_pkg::*;

  logic [4:0] pos;
  logic       in_header;
  logic       in_uuid;
  logic       full;
  logic       empty;
  logic       push;
  tag_item_t  tag_in;
  logic [$bits(tag_item_t)-1:0] pop_bits;

  // A transfer is taken whenever the queue has room.
  assign box.ready = !full;
  assign push      = box.valid && !full;

  // Classify the byte by its place in the fixed 24-byte header.
  assign in_header = (pos < HEADER_BYTES);
  assign in_uuid   = (pos >= UUID_START) && in_header;

  always_comb begin
    tag_in.box_byte    = box.box_byte;
    tag_in.last_byte   = box.last_byte;
    tag_in.uuid_bad    = in_uuid && (box.box_byte != uuid_byte(4'(pos - UUID_START)));
    tag_in.header_done = (pos == HEADER_BYTES - 5'd1);
  end

  // Header position, held once the header is through.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push && in_header) begin
      pos <= pos + 5'd1;
    end
  end

  psebp_queue #(
    .WIDTH ($bits(tag_item_t)),
    .DEPTH (DEPTH)
  ) u_in_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (tag_in),
    .full      (full),
    .pop       (item_pop),
    .pop_data  (pop_bits),
    .empty     (empty)
  );

  assign item       = tag_item_t'(pop_bits);
  assign item_valid = !empty;

endmodule

`default_nettype wire

// ===== src/psebp_parse.sv =====
`default_nettype none

module psebp_parse (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [31:0]          sample_index,
  input  wire logic [7:0]           default_iv_size,
  input  wire psebp_pkg::tag_item_t item,
  input  wire logic                 item_valid,
  output logic                      item_pop,
  input  wire logic                 res_full,
  output logic                      res_push,
  output psebp_pkg::result_t        res
);

  import psebp_pkg::*;

  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_VERFLAGS = 4'd1;
  localparam logic [3:0] PH_ALG      = 4'd2;
  localparam logic [3:0] PH_IVSIZE   = 4'd3;
  localparam logic [3:0] PH_KID      = 4'd4;
  localparam logic [3:0] PH_COUNT    = 4'd5;
  localparam logic [3:0] PH_IV       = 4'd6;
  localparam logic [3:0] PH_NENT     = 4'd7;
  localparam logic [3:0] PH_ENTRY    = 4'd8;
  localparam logic [3:0] PH_SKIP     = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [4:0]  field_byte_count, field_byte_count_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [1:0]  flag_bits, flag_bits_next;
  logic [7:0]  iv_size, iv_size_next;
  logic [31:0] sample_counter, sample_counter_next;
  logic [15:0] entries_left, entries_left_next;
  logic [18:0] skip_bytes_left, skip_bytes_left_next;
  logic        finished, finished_next;
  logic [15:0] held_clear, held_clear_next;

  logic        fire;
  logic        chosen;
  logic [31:0] acc_shift;
  logic [4:0]  cnt_inc;
  logic [18:0] skip_dec;
  logic [18:0] skip_mul;
  logic [15:0] entries_dec;
  logic        have;
  logic        fin;
  logic        known_phase;
  result_t     res_d;

  assign fire     = item_valid && !res_full;
  assign item_pop = fire;
  assign chosen   = (sample_counter == sample_index);

  assign acc_shift   = {field_accumulator[23:0], item.box_byte};
  assign cnt_inc     = field_byte_count + 5'd1;
  assign skip_dec    = skip_bytes_left - 19'd1;
  assign entries_dec = entries_left - 16'd1;
  // Entry count times six, as shift-and-add.
  assign skip_mul    = {1'b0, acc_shift[15:0], 2'b00} + {2'b00, acc_shift[15:0], 1'b0};

  // Field assembly and phase sequencing for one byte.
  always_comb begin
    phase_next             = phase;
    field_byte_count_next  = field_byte_count;
    field_accumulator_next = field_accumulator;
    flag_bits_next         = flag_bits;
    iv_size_next           = iv_size;
    sample_counter_next    = sample_counter;
    entries_left_next      = entries_left;
    skip_bytes_left_next   = skip_bytes_left;
    held_clear_next        = held_clear;
    finished_next          = finished;
    have                   = 1'b0;
    fin                    = 1'b0;
    known_phase            = 1'b1;
    res_d                  = '0;

    if (fire && !finished) begin
      case (phase)
        PH_HEADER: begin
          if (item.uuid_bad) begin
            have         = 1'b1;
            fin          = 1'b1;
            res_d.kind   = KIND_ERROR;
            res_d.status = STATUS_BAD_PARAM;
          end else if (item.header_done) begin
            field_byte_count_next  = '0;
            field_accumulator_next = '0;
            phase_next             = PH_VERFLAGS;
          end
        end
        PH_VERFLAGS: begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = cnt_inc;
          if (cnt_inc >= 5'd4) begin
            field_byte_count_next = '0;
            flag_bits_next        = acc_shift[1:0];
            if (acc_shift[0]) begin
              phase_next = PH_ALG;
            end else begin
              iv_size_next = (default_iv_size == 8'd0) ? IV_SIZE_ZERO_MEANS
                                                       : default_iv_size;
              phase_next   = PH_COUNT;
            end
          end
        end
        PH_ALG: begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = cnt_inc;
          if (cnt_inc >= 5'd3) begin
            field_byte_count_next = '0;
            phase_next            = PH_IVSIZE;
          end
        end
        PH_IVSIZE: begin
          iv_size_next = (item.box_byte == 8'd0) ? IV_SIZE_ZERO_MEANS : item.box_byte;
          phase_next   = PH_KID;
        end
        PH_KID: begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = cnt_inc;
          if (cnt_inc >= 5'd16) begin
            field_byte_count_next = '0;
            phase_next            = PH_COUNT;
          end
        end
        PH_COUNT: begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = cnt_inc;
          if (cnt_inc >= 5'd4) begin
            field_byte_count_next = '0;
            sample_counter_next   = '0;
            if (sample_index >= acc_shift) begin
              have         = 1'b1;
              fin          = 1'b1;
              res_d.kind   = KIND_ERROR;
              res_d.status = STATUS_BAD_DRM;
            end else begin
              skip_bytes_left_next = {11'd0, iv_size};
              phase_next           = PH_IV;
            end
          end
        end
        PH_IV: begin
          if (chosen) begin
            have          = 1'b1;
            res_d.kind    = KIND_IV_BYTE;
            res_d.iv_byte = item.box_byte;
          end
          skip_bytes_left_next = skip_dec;
          if (skip_dec == '0) begin
            if (flag_bits[1]) begin
              field_byte_count_next = '0;
              phase_next            = PH_NENT;
            end else if (chosen) begin
              fin = 1'b1;
            end else begin
              sample_counter_next  = sample_counter + 32'd1;
              skip_bytes_left_next = {11'd0, iv_size};
            end
          end
        end
        PH_NENT: begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = cnt_inc;
          if (cnt_inc >= 5'd2) begin
            field_byte_count_next = '0;
            if (chosen) begin
              have              = 1'b1;
              res_d.kind        = KIND_ENTRY_COUNT;
              res_d.entry_count = acc_shift[15:0];
              if (acc_shift[15:0] == 16'd0) begin
                fin = 1'b1;
              end else begin
                entries_left_next = acc_shift[15:0];
                phase_next        = PH_ENTRY;
              end
            end else if (skip_mul == '0) begin
              sample_counter_next  = sample_counter + 32'd1;
              skip_bytes_left_next = {11'd0, iv_size};
              phase_next           = PH_IV;
            end else begin
              skip_bytes_left_next = skip_mul;
              phase_next           = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_bytes_left_next = skip_dec;
          if (skip_dec == '0) begin
            sample_counter_next  = sample_counter + 32'd1;
            skip_bytes_left_next = {11'd0, iv_size};
            phase_next           = PH_IV;
          end
        end
        PH_ENTRY: begin
          field_accumulator_next = acc_shift;
          field_byte_count_next  = cnt_inc;
          if (cnt_inc >= ENTRY_BYTES) begin
            field_byte_count_next = '0;
            have                  = 1'b1;
            res_d.kind            = KIND_ENTRY;
            res_d.clear_bytes     = held_clear;
            res_d.encrypted_bytes = acc_shift;
            entries_left_next     = entries_dec;
            if (entries_dec == '0) begin
              fin = 1'b1;
            end
          end else if (cnt_inc == 5'd2) begin
            held_clear_next = acc_shift[15:0];
          end
        end
        default: begin
          known_phase = 1'b0;
        end
      endcase

      if (fin) begin
        finished_next = 1'b1;
      end

      // A box that ends before the run is done is a bad parameter.
      if (known_phase && item.last_byte && !finished_next) begin
        have          = 1'b1;
        fin           = 1'b1;
        finished_next = 1'b1;
        res_d         = '0;
        res_d.kind    = KIND_ERROR;
        res_d.status  = STATUS_BAD_PARAM;
      end
      res_d.final_res = fin;
    end
  end

  assign res_push = fire && !finished && have;
  assign res      = res_d;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      field_byte_count  <= '0;
      field_accumulator <= '0;
      flag_bits         <= '0;
      iv_size           <= '0;
      sample_counter    <= '0;
      entries_left      <= '0;
      skip_bytes_left   <= '0;
      finished          <= 1'b0;
      held_clear        <= '0;
    end else begin
      phase             <= phase_next;
      field_byte_count  <= field_byte_count_next;
      field_accumulator <= field_accumulator_next;
      flag_bits         <= flag_bits_next;
      iv_size           <= iv_size_next;
      sample_counter    <= sample_counter_next;
      entries_left      <= entries_left_next;
      skip_bytes_left   <= skip_bytes_left_next;
      finished          <= finished_next;
      held_clear        <= held_clear_next;
    end
  end

  // Once the run has ended, no further result leaves the parser.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    finished |-> !res_push)
    else $error("result pushed after the run ended");

  // A final result always ends the run.
  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.final_res) |=> finished)
    else $error("final result did not end the run");

  // Errors are always final.
  a_error_final: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.kind == KIND_ERROR) |-> res.final_res)
    else $error("error result not marked final");

  // While an IV is being read there is always at least one byte of it left.
  a_iv_left: assert property (@(posedge clk) disable iff (rst)
    (!finished && phase == PH_IV) |-> (skip_bytes_left != '0))
    else $error("IV byte count ran out");

endmodule

`default_nettype wire

// ===== src/piff_sample_encryption_box_parser.sv =====
`default_nettype none

// Channel  | Dir | Handshake    | Payload
// box      | in  | valid/ready  | box_byte[7:0], last_byte
// result   | out | valid/ready  | kind, iv_byte, entry_count, clear_bytes,
//          |     |              | encrypted_bytes, status, final_res
// cfg      | in  | valid/ready  | index, data[31:0]; ready is always high
//
// One box byte per cycle is taken and parsed unless a queue is full; a result
// leaves from the result queue at one per cycle while the sink is ready.
// Each byte moves through an input queue and the parser, and each result through
// a result queue, both of QUEUE_DEPTH entries, so either side can stall alone.
// rst is synchronous and clears the parser, queues and registers; no clearing
// pass is needed.
// After the final result every further byte is taken and dropped until reset.

module piff_sample_encryption_box_parser #(
  parameter int QUEUE_DEPTH = psebp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  psebp_in_if.sink   box,
  psebp_out_if.source result,
  psebp_cfg_if.sink  cfg
);

  import psebp_pkg::*;

  logic [31:0] sample_index;
  logic [7:0]  default_iv_size;
  tag_item_t   item;
  logic        item_valid;
  logic        item_pop;
  logic        res_full;
  logic        res_push;
  result_t     res_in;
  result_t     res_out;
  logic        res_empty;
  logic [$bits(result_t)-1:0] res_bits;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index    <= '0;
      default_iv_size <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SAMPLE_INDEX:    sample_index    <= cfg.data;
        CFG_DEFAULT_IV_SIZE: default_iv_size <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Front: byte intake and header classification.
  psebp_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .box        (box),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // Back: field parsing and result generation.
  psebp_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .sample_index    (sample_index),
    .default_iv_size (default_iv_size),
    .item            (item),
    .item_valid      (item_valid),
    .item_pop        (item_pop),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (res_in)
  );

  // Result queue toward the sink.
  psebp_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (result.valid && result.ready),
    .pop_data  (res_bits),
    .empty     (res_empty)
  );

  assign res_out                = result_t'(res_bits);
  assign result.valid           = !res_empty;
  assign result.kind            = res_out.kind;
  assign result.iv_byte         = res_out.iv_byte;
  assign result.entry_count     = res_out.entry_count;
  assign result.clear_bytes     = res_out.clear_bytes;
  assign result.encrypted_bytes = res_out.encrypted_bytes;
  assign result.status          = res_out.status;
  assign result.final_res       = res_out.final_res;

endmodule

`default_nettype wire
